// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that must hold at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that must hold even while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/ois_pkg.sv =====
// ----------------------------------------------------------------------------
// ois_pkg: shared types and constants for the ordered integer set unit
// Command codes, beat structs and bit scan helpers.
// ----------------------------------------------------------------------------
package ois_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned LeafN  = 1024;
  localparam int unsigned MidN   = 16;
  localparam int unsigned LeafAw = 10;
  localparam int unsigned MidAw  = 4;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_ERASE  = 3'd1,
    CMD_MEMBER = 3'd2,
    CMD_SUCC   = 3'd3,
    CMD_PRED   = 3'd4,
    CMD_MIN    = 3'd5,
    CMD_MAX    = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [KeyW-1:0] value;
    logic            was_present;
  } rsp_t;

  // Lowest set bit of a 64-bit word; zero when the word is empty.
  function automatic logic [5:0] low_bit(input logic [63:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (w[i]) r = 6'(i);
    end
    return r;
  endfunction

  // Highest set bit of a 64-bit word; zero when the word is empty.
  function automatic logic [5:0] high_bit(input logic [63:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [63:0] mask_above(input logic [5:0] p);
    return (p == 6'd63) ? 64'd0 : ({64{1'b1}} << (7'(p) + 7'd1));
  endfunction

  function automatic logic [63:0] mask_below(input logic [5:0] p);
    return (64'd1 << p) - 64'd1;
  endfunction

endpackage

// ===== hdl/ordered_integer_set_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_integer_set_unit: ordered set of 16-bit keys
// Three-level bitmap (leaf words, middle summary, top summary); leaf words in a memory.
// ----------------------------------------------------------------------------
// Member, insert and erase read the key's leaf word; successor, predecessor, minimum
// and maximum take longer when a second leaf word is read. One command at a time;
// a new command is accepted in the strobe cycle at the earliest. Reset and clear
// sweep the 1024 leaf words, one per cycle, with busy high throughout; a clear
// strobes its result in the cycle after acceptance. The receiver cannot stall.
module ordered_integer_set_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ois_pkg::req_t  req_i,
  output logic           done_o,
  output ois_pkg::rsp_t  rsp_o
);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD0   = 9'b000000100,  // leaf word of the key is being read
    S_EV0   = 9'b000001000,  // leaf word of the key available
    S_RD1   = 9'b000010000,  // second leaf word read is in flight
    S_EV1   = 9'b000100000,  // second leaf word available
    S_ER2   = 9'b001000000,  // erase: middle summary update
    S_DONE  = 9'b010000000,
    S_MINR  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // The leaf memory: one bit per key, synchronous read.
  logic [63:0] leaf_mem [ois_pkg::LeafN];
  logic [63:0] leaf_rd_q;
  logic        leaf_we;
  logic [ois_pkg::LeafAw-1:0] leaf_wa, leaf_ra;
  logic [63:0] leaf_wd;

  // The middle and top summaries are small enough for flip-flops; middle words
  // are read at two places, by the key's middle index and by the top summary search.
  logic [63:0] mid_q [ois_pkg::MidN];
  logic [15:0] top_q;

  logic [ois_pkg::LeafAw:0] clr_cnt_q;
  logic [2:0]  cmd_q;
  logic [15:0] key_q;
  logic        present_q;
  logic [ois_pkg::LeafAw-1:0] l2_q;   // leaf index of the second read
  ois_pkg::rsp_t rsp_q, rsp_d;
  logic        done_q;

  logic [ois_pkg::LeafAw-1:0] key_l;
  logic [ois_pkg::MidAw-1:0]  key_m;
  logic [5:0]  key_b;
  assign key_l = key_q[15:6];
  assign key_m = key_q[15:12];
  assign key_b = key_q[5:0];

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    leaf_rd_q <= leaf_mem[leaf_ra];
  end

  // Search signals out of the first leaf read.
  logic [63:0] lw_hit, mw_hit, mw, lw_new;
  logic [15:0] tw_hit;
  logic [5:0]  tw_bit;
  logic        is_succ;
  logic [ois_pkg::MidAw-1:0] m2;
  logic [ois_pkg::LeafAw-1:0] l_next;
  logic        have_l;

  always_comb begin
    is_succ = (cmd_q == ois_pkg::CMD_SUCC) || (cmd_q == ois_pkg::CMD_MIN);
    mw      = mid_q[key_m];
    lw_hit  = is_succ ? (leaf_rd_q & ois_pkg::mask_above(key_b))
                      : (leaf_rd_q & ois_pkg::mask_below(key_b));
    mw_hit  = is_succ ? (mw & ois_pkg::mask_above(key_l[5:0]))
                      : (mw & ois_pkg::mask_below(key_l[5:0]));
    tw_hit  = is_succ ? (top_q & ~((16'd2 << key_m) - 16'd1))
                      : (top_q & ((16'd1 << key_m) - 16'd1));
    // Minimum and maximum search the whole top word.
    if (cmd_q == ois_pkg::CMD_MIN || cmd_q == ois_pkg::CMD_MAX) begin
      tw_hit = top_q;
      mw_hit = '0;
    end
    tw_bit = is_succ ? ois_pkg::low_bit({48'd0, tw_hit})
                     : ois_pkg::high_bit({48'd0, tw_hit});
    m2 = tw_bit[3:0];
    have_l = 1'b1;
    if (mw_hit != '0) begin
      l_next = {key_m, is_succ ? ois_pkg::low_bit(mw_hit) : ois_pkg::high_bit(mw_hit)};
    end else if (tw_hit != '0) begin
      l_next = {m2, is_succ ? ois_pkg::low_bit(mid_q[m2]) : ois_pkg::high_bit(mid_q[m2])};
    end else begin
      l_next = '0;
      have_l = 1'b0;
    end
    lw_new = leaf_rd_q & ~(64'd1 << key_b);
  end

  always_comb begin
    state_d = state_q;
    leaf_we = 1'b0;
    leaf_wa = key_l;
    leaf_wd = '0;
    leaf_ra = key_l;
    rsp_d   = '0;
    case (state_q)
      S_CLR: begin
        leaf_we = 1'b1;
        leaf_wa = clr_cnt_q[ois_pkg::LeafAw-1:0];
        if (clr_cnt_q[ois_pkg::LeafAw-1:0] == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        leaf_ra = req_i.key[15:6];
        if (start) begin
          state_d = (req_i.cmd == ois_pkg::CMD_CLEAR) ? S_CLR :
                    (req_i.cmd == ois_pkg::CMD_MIN || req_i.cmd == ois_pkg::CMD_MAX)
                    ? S_MINR : S_RD0;
        end
      end
      S_MINR: state_d = S_EV0;
      S_RD0:  state_d = S_EV0;
      S_EV0: begin
        case (cmd_q)
          ois_pkg::CMD_INSERT: begin
            leaf_we = 1'b1;
            leaf_wd = leaf_rd_q | (64'd1 << key_b);
            state_d = S_DONE;
          end
          ois_pkg::CMD_ERASE: begin
            leaf_we = 1'b1;
            leaf_wd = lw_new;
            state_d = S_DONE;
          end
          ois_pkg::CMD_SUCC, ois_pkg::CMD_PRED: begin
            if (lw_hit != '0) begin
              state_d = S_DONE;
            end else if (have_l) begin
              leaf_ra = l_next;
              state_d = S_EV1;
            end else begin
              state_d = S_DONE;
            end
          end
          ois_pkg::CMD_MIN, ois_pkg::CMD_MAX: begin
            leaf_ra = l_next;
            state_d = have_l ? S_EV1 : S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_EV1: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_EV0 && state_d == S_DONE) begin
      if ((cmd_q == ois_pkg::CMD_SUCC || cmd_q == ois_pkg::CMD_PRED) && lw_hit != '0) begin
        rsp_d.found = 1'b1;
        rsp_d.value = {key_l, is_succ ? ois_pkg::low_bit(lw_hit) : ois_pkg::high_bit(lw_hit)};
      end
    end
    if (state_q == S_EV1) begin
      rsp_d.found = 1'b1;
      rsp_d.value = {l2_q, is_succ ? ois_pkg::low_bit(leaf_rd_q)
                                   : ois_pkg::high_bit(leaf_rd_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
      top_q     <= '0;
      for (int i = 0; i < ois_pkg::MidN; i++) mid_q[i] <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (state_d == S_IDLE) done_q <= 1'b0;
      end
      if (state_q == S_IDLE && start && req_i.cmd == ois_pkg::CMD_CLEAR) begin
        clr_cnt_q <= '0;
        top_q     <= '0;
        for (int i = 0; i < ois_pkg::MidN; i++) mid_q[i] <= '0;
        done_q    <= 1'b1;
      end
      if (state_q == S_EV0 && cmd_q == ois_pkg::CMD_INSERT) begin
        mid_q[key_m][key_l[5:0]] <= 1'b1;
        top_q[key_m] <= 1'b1;
      end
      if (state_q == S_EV0 && cmd_q == ois_pkg::CMD_ERASE && lw_new == '0) begin
        mid_q[key_m][key_l[5:0]] <= 1'b0;
        if ((mw & ~(64'd1 << key_l[5:0])) == '0) top_q[key_m] <= 1'b0;
      end
      if (state_q == S_DONE) done_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
      rsp_q <= '0;
    end
    if (state_q == S_EV0) begin
      present_q <= leaf_rd_q[key_b];
      l2_q      <= l_next;
      rsp_q     <= rsp_d;
    end
    if (state_q == S_EV1) rsp_q <= rsp_d;
  end

  logic keyed;
  assign keyed = (cmd_q != ois_pkg::CMD_MIN) && (cmd_q != ois_pkg::CMD_MAX) &&
                 (cmd_q != ois_pkg::CMD_CLEAR);

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  always_comb begin
    rsp_o = rsp_q;
    rsp_o.was_present = keyed & present_q;
    if (cmd_q == ois_pkg::CMD_CLEAR) rsp_o = '0;
  end

endmodule

// ===== hdl/ois_checker.sv =====
// ----------------------------------------------------------------------------
// ois_checker: port-level checks for the ordered integer set unit
// Watches the command and result beats over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ois_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input ois_pkg::rsp_t rsp_o
);
  `ASSERT_IMPL(a_no_found_zero, clk_i, rst_ni, (done_o && !rsp_o.found) |-> (rsp_o.value == '0), "value must be zero when not found")
  `ASSERT_IMPL(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "busy must rise after an accepted beat")
  `ASSERT_IMPL(a_done_has_cmd, clk_i, rst_ni, done_o |-> ($past(busy) || $past(start)), "result strobe without a command in progress")
  `ASSERT_ALWAYS(a_reset_busy, clk_i, !rst_ni |=> busy, "busy must be high after reset")
endmodule

bind ordered_integer_set_unit ois_checker u_ois_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .rsp_o(rsp_o)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the ordered integer set unit
// Drives set commands through the start/busy handshake, predicts each result
// beat with a flat bitmap of the key space, and compares every field.
// ----------------------------------------------------------------------------
module tb_top;

  // Scoreboard: holds its own copy of the set and a queue of predicted beats.
  class set_scoreboard;
    bit            members[65536];
    ois_pkg::rsp_t pending[$];
    int            errors;

    function void wipe();
      foreach (members[i]) members[i] = 1'b0;
    endfunction

    // Nearest member strictly above (up = 1) or below (up = 0) the key.
    function void scan(input int key, input bit up, output bit hit,
                       output logic [15:0] val);
      int k;
      hit = 1'b0;
      val = '0;
      k = up ? key + 1 : key - 1;
      while (k >= 0 && k <= 65535) begin
        if (members[k]) begin
          hit = 1'b1;
          val = 16'(k);
          return;
        end
        k = up ? k + 1 : k - 1;
      end
    endfunction

    function void note_command(input ois_pkg::req_t r);
      ois_pkg::rsp_t e;
      int            key;
      key = int'(r.key);
      e = '0;
      case (ois_pkg::cmd_e'(r.cmd))
        ois_pkg::CMD_INSERT: begin
          e.was_present = members[key];
          members[key] = 1'b1;
        end
        ois_pkg::CMD_ERASE: begin
          e.was_present = members[key];
          members[key] = 1'b0;
        end
        ois_pkg::CMD_MEMBER: e.was_present = members[key];
        ois_pkg::CMD_SUCC: begin
          e.was_present = members[key];
          scan(key, 1'b1, e.found, e.value);
        end
        ois_pkg::CMD_PRED: begin
          e.was_present = members[key];
          scan(key, 1'b0, e.found, e.value);
        end
        ois_pkg::CMD_MIN: scan(-1, 1'b1, e.found, e.value);
        ois_pkg::CMD_MAX: scan(65536, 1'b0, e.found, e.value);
        default: wipe();
      endcase
      pending.push_back(e);
    endfunction

    function void check_beat(input ois_pkg::rsp_t a);
      ois_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, a.found);
        errors++;
      end
      if (a.value !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, a.value);
        errors++;
      end
      if (a.was_present !== e.was_present) begin
        $error("was_present: expected %0d, got %0d", e.was_present, a.was_present);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  ois_pkg::req_t req_i = '0;
  logic          done_o;
  ois_pkg::rsp_t rsp_o;

  set_scoreboard sb = new();
  int unsigned   cycles;
  // Keys recently inserted, so erases and queries often hit live members.
  logic [15:0]   live_keys[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ordered_integer_set_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // A command beat is taken at an edge where start is high and busy is low.
  // The prediction is made at that same edge so its order matches the block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) sb.note_command(req_i);
    if (rst_ni && done_o) sb.check_beat(rsp_o);
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one command, after a random gap when idle is set; returns at its accepting edge with
  // start still high, so a back-to-back command never toggles it twice.
  task automatic send_cmd(input ois_pkg::cmd_e c, input logic [15:0] k, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{cmd: c, key: k};
    do @(posedge clk_i); while (busy);
    if (c == ois_pkg::CMD_INSERT) live_keys.push_back(k);
    if (live_keys.size() > 64) void'(live_keys.pop_front());
  endtask

  // Stops sending and waits until every predicted beat has arrived.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Picks a key: near a live member, near a cluster edge, or fully random.
  function automatic logic [15:0] pick_key();
    logic [15:0] k;
    case ($urandom_range(0, 5))
      0, 1: k = live_keys.size() ? live_keys[$urandom_range(0, live_keys.size() - 1)]
                                 : 16'($urandom);
      2: k = live_keys.size() ? live_keys[$urandom_range(0, live_keys.size() - 1)]
                                  + 16'($urandom_range(0, 4)) - 16'd2
                              : 16'($urandom);
      3: k = {4'($urandom), 6'($urandom_range(0, 1) ? 6'd0 : 6'd63),
              6'($urandom_range(0, 1) ? 6'd0 : 6'd63)};
      default: k = 16'($urandom);
    endcase
    return k;
  endfunction

  initial begin
    ois_pkg::cmd_e c;
    bit            idle;
    sb.wipe();
    cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty-set queries, extremes of the key, strict bounds,
    // duplicate insert, absent erase and clear.
    send_cmd(ois_pkg::CMD_MIN,    16'h0000, 1'b0);
    send_cmd(ois_pkg::CMD_MAX,    16'hffff, 1'b0);
    send_cmd(ois_pkg::CMD_SUCC,   16'h1234, 1'b0);
    send_cmd(ois_pkg::CMD_PRED,   16'h1234, 1'b0);
    send_cmd(ois_pkg::CMD_INSERT, 16'h0000, 1'b0);
    send_cmd(ois_pkg::CMD_INSERT, 16'hffff, 1'b0);
    send_cmd(ois_pkg::CMD_INSERT, 16'hffff, 1'b0);
    send_cmd(ois_pkg::CMD_MEMBER, 16'hffff, 1'b0);
    send_cmd(ois_pkg::CMD_SUCC,   16'hffff, 1'b0);
    send_cmd(ois_pkg::CMD_PRED,   16'h0000, 1'b0);
    send_cmd(ois_pkg::CMD_SUCC,   16'h0000, 1'b0);
    send_cmd(ois_pkg::CMD_PRED,   16'hffff, 1'b0);
    send_cmd(ois_pkg::CMD_INSERT, 16'h0fc0, 1'b0);
    send_cmd(ois_pkg::CMD_INSERT, 16'h003f, 1'b0);
    send_cmd(ois_pkg::CMD_SUCC,   16'h003f, 1'b0);
    send_cmd(ois_pkg::CMD_PRED,   16'h0fc0, 1'b0);
    send_cmd(ois_pkg::CMD_ERASE,  16'h5555, 1'b0);
    send_cmd(ois_pkg::CMD_ERASE,  16'h0000, 1'b0);
    send_cmd(ois_pkg::CMD_MIN,    16'haaaa, 1'b0);
    send_cmd(ois_pkg::CMD_MAX,    16'h5555, 1'b0);
    send_cmd(ois_pkg::CMD_CLEAR,  16'h0000, 1'b0);
    send_cmd(ois_pkg::CMD_MEMBER, 16'h0fc0, 1'b0);
    send_cmd(ois_pkg::CMD_MAX,    16'h0000, 1'b0);
    live_keys.delete();

    // Random part, in bursts with or without idle gaps. Inserts dominate so
    // the set grows; a rare clear empties it again.
    for (int n = 0; n < 850; n++) begin
      if (n % 100 == 0) idle = $urandom_range(0, 2) != 0;
      if (n == 400) drain();
      case ($urandom_range(0, 99))
        0: c = ois_pkg::CMD_CLEAR;
        default: c = ois_pkg::cmd_e'($urandom_range(0, 99) < 35 ? 0 : $urandom_range(1, 6));
      endcase
      if (c == ois_pkg::CMD_CLEAR) live_keys.delete();
      send_cmd(c, pick_key(), idle);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ois_pkg.sv
hdl/ordered_integer_set_unit.sv
hdl/ois_checker.sv
dv/tb_top.sv
